// ----- hdl/irclt_pkg.sv -----
// shared types and constants of the irc line tokenizer
// record layout, scanner phases, character codes and queue sizing
// no dependencies
package irclt_pkg;

  localparam int MAX_LINE = 512;
  localparam int POS_W    = $clog2(MAX_LINE) + 1;
  localparam int OFF_W    = 9;
  localparam int PIDX_W   = 4;
  localparam int MAX_RECS = 3;
  localparam int Q_DEPTH  = 4;
  localparam int CNT_W    = $clog2(Q_DEPTH + 1);
  localparam int TDATA_W  = 32;

  localparam logic [PIDX_W-1:0] PARAM_LIMIT = 4'd15;
  localparam logic [PIDX_W-1:0] MAXP_RESET  = 4'd15;

  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_COLON = 8'h3A;
  localparam logic [7:0] CH_SP    = 8'h20;

  typedef enum logic [2:0] {
    PH_START,
    PH_PREFIX,
    PH_CMD,
    PH_GAP,
    PH_MIDDLE,
    PH_TRAIL,
    PH_HALT
  } phase_t;

  typedef enum logic [2:0] {
    K_PREFIX,
    K_CMD,
    K_MIDDLE,
    K_TRAIL,
    K_STATUS
  } kind_t;

  typedef enum logic [2:0] {
    ST_OK,
    ST_BAD_END,
    ST_PREFIX,
    ST_NO_SPACE,
    ST_PARAMS,
    ST_LONG
  } status_t;

  typedef struct packed {
    kind_t             kind;
    logic [OFF_W-1:0]  offset;
    logic [OFF_W-1:0]  length;
    logic [PIDX_W-1:0] pidx;
    status_t           status;
    logic              last;
  } rec_t;

  typedef struct packed {
    logic [1:0]                cnt;
    rec_t [MAX_RECS-1:0]       recs;
  } push_t;

endpackage

// ----- hdl/irclt_scan.sv -----
// byte scanner of the irc line tokenizer: line state and record generation
// holds back the last two bytes and emits up to two records per byte
// depends on irclt_pkg
module irclt_scan (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  input  logic [7:0]                    in_byte,
  input  logic                          in_last,
  input  logic [irclt_pkg::PIDX_W-1:0]  max_params,
  output irclt_pkg::push_t              push
);

  irclt_pkg::phase_t               phase;
  logic [irclt_pkg::POS_W-1:0]     position;
  logic [irclt_pkg::OFF_W-1:0]     token_start;
  logic [irclt_pkg::PIDX_W-1:0]    param_count;
  irclt_pkg::status_t              error_code;
  logic [7:0]                      held0;
  logic [7:0]                      held1;

  irclt_pkg::phase_t               phase_b;
  logic [irclt_pkg::OFF_W-1:0]     ts_b;
  logic [irclt_pkg::PIDX_W-1:0]    pc_b;
  irclt_pkg::status_t              err_b;

  logic                            ovf;
  logic                            run;
  logic                            is_sp;
  logic                            start_col;
  irclt_pkg::phase_t               eph;
  logic [irclt_pkg::OFF_W-1:0]     p;
  logic [irclt_pkg::OFF_W-1:0]     ets;
  logic [irclt_pkg::PIDX_W-1:0]    cap;

  irclt_pkg::rec_t                 body_rec;
  irclt_pkg::rec_t                 flush_rec;
  irclt_pkg::rec_t                 stat_rec;
  logic                            body_v;
  logic                            flush_v;
  logic                            stat_v;
  logic [irclt_pkg::OFF_W-1:0]     body_len;

  // decode shared by next state and outputs
  always_comb begin
    ovf       = position >= irclt_pkg::POS_W'(irclt_pkg::MAX_LINE);
    run       = in_valid && !ovf && (position >= irclt_pkg::POS_W'(2)) &&
                (error_code == irclt_pkg::ST_OK) && (phase != irclt_pkg::PH_HALT);
    p         = position[irclt_pkg::OFF_W-1:0] - irclt_pkg::OFF_W'(2);
    is_sp     = held0 == irclt_pkg::CH_SP;
    start_col = (phase == irclt_pkg::PH_START) && (held0 == irclt_pkg::CH_COLON);
    eph       = (phase == irclt_pkg::PH_START) ? irclt_pkg::PH_CMD : phase;
    ets       = (phase == irclt_pkg::PH_START) ? p : token_start;
    cap       = (max_params > irclt_pkg::PARAM_LIMIT) ? irclt_pkg::PARAM_LIMIT : max_params;
    body_len  = position[irclt_pkg::OFF_W-1:0] - irclt_pkg::OFF_W'(1);
  end

  // next state after the body byte
  always_comb begin
    phase_b = phase;
    ts_b    = token_start;
    pc_b    = param_count;
    err_b   = error_code;
    if (ovf) begin
      err_b   = irclt_pkg::ST_LONG;
      phase_b = irclt_pkg::PH_HALT;
    end else if (run) begin
      if (start_col) begin
        phase_b = irclt_pkg::PH_PREFIX;
        ts_b    = p + irclt_pkg::OFF_W'(1);
      end else begin
        phase_b = eph;
        ts_b    = ets;
        unique case (eph)
          irclt_pkg::PH_PREFIX: begin
            if (is_sp) begin
              phase_b = irclt_pkg::PH_CMD;
              ts_b    = p + irclt_pkg::OFF_W'(1);
            end
          end
          irclt_pkg::PH_CMD: begin
            if (is_sp) phase_b = irclt_pkg::PH_GAP;
          end
          irclt_pkg::PH_GAP: begin
            if (!is_sp) begin
              if (param_count >= cap) begin
                err_b   = irclt_pkg::ST_PARAMS;
                phase_b = irclt_pkg::PH_HALT;
              end else begin
                pc_b = param_count + irclt_pkg::PIDX_W'(1);
                if (held0 == irclt_pkg::CH_COLON) begin
                  ts_b    = p + irclt_pkg::OFF_W'(1);
                  phase_b = irclt_pkg::PH_TRAIL;
                end else begin
                  ts_b    = p;
                  phase_b = irclt_pkg::PH_MIDDLE;
                end
              end
            end
          end
          irclt_pkg::PH_MIDDLE: begin
            if (is_sp) phase_b = irclt_pkg::PH_GAP;
          end
          default: begin
          end
        endcase
      end
    end
  end

  // record outputs
  always_comb begin
    body_rec        = '0;
    body_rec.offset = ets;
    body_rec.length = p - ets;
    body_rec.kind   = irclt_pkg::K_CMD;
    body_v          = 1'b0;
    if (run && !start_col && is_sp) begin
      unique case (eph)
        irclt_pkg::PH_PREFIX: begin
          body_rec.kind = irclt_pkg::K_PREFIX;
          body_v        = 1'b1;
        end
        irclt_pkg::PH_CMD: begin
          body_rec.kind = irclt_pkg::K_CMD;
          body_v        = 1'b1;
        end
        irclt_pkg::PH_MIDDLE: begin
          body_rec.kind = irclt_pkg::K_MIDDLE;
          body_rec.pidx = param_count - irclt_pkg::PIDX_W'(1);
          body_v        = 1'b1;
        end
        default: begin
        end
      endcase
    end

    flush_rec        = '0;
    flush_rec.kind   = irclt_pkg::K_MIDDLE;
    flush_rec.offset = ts_b;
    flush_rec.length = body_len - ts_b;
    flush_rec.pidx   = pc_b - irclt_pkg::PIDX_W'(1);
    flush_v          = 1'b0;

    stat_rec        = '0;
    stat_rec.kind   = irclt_pkg::K_STATUS;
    stat_rec.last   = 1'b1;
    stat_rec.status = irclt_pkg::ST_OK;
    stat_v          = in_valid && in_last;

    if (err_b == irclt_pkg::ST_LONG) begin
      stat_rec.status = irclt_pkg::ST_LONG;
    end else if ((position < irclt_pkg::POS_W'(2)) || (held1 != irclt_pkg::CH_CR) ||
                 (in_byte != irclt_pkg::CH_LF)) begin
      stat_rec.status = irclt_pkg::ST_BAD_END;
    end else if (err_b != irclt_pkg::ST_OK) begin
      stat_rec.status = err_b;
    end else begin
      unique case (phase_b) inside
        irclt_pkg::PH_PREFIX: stat_rec.status = irclt_pkg::ST_PREFIX;
        irclt_pkg::PH_START, irclt_pkg::PH_CMD: stat_rec.status = irclt_pkg::ST_NO_SPACE;
        irclt_pkg::PH_MIDDLE: flush_v = stat_v;
        irclt_pkg::PH_TRAIL: begin
          flush_rec.kind = irclt_pkg::K_TRAIL;
          flush_v        = stat_v;
        end
        default: begin
        end
      endcase
    end

    push = '0;
    if (body_v) begin
      push.recs[push.cnt] = body_rec;
      push.cnt            = push.cnt + 2'd1;
    end
    if (flush_v) begin
      push.recs[push.cnt] = flush_rec;
      push.cnt            = push.cnt + 2'd1;
    end
    if (stat_v) begin
      push.recs[push.cnt] = stat_rec;
      push.cnt            = push.cnt + 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase       <= irclt_pkg::PH_START;
      position    <= '0;
      token_start <= '0;
      param_count <= '0;
      error_code  <= irclt_pkg::ST_OK;
    end else if (in_valid) begin
      if (in_last) begin
        phase       <= irclt_pkg::PH_START;
        position    <= '0;
        token_start <= '0;
        param_count <= '0;
        error_code  <= irclt_pkg::ST_OK;
      end else begin
        phase       <= phase_b;
        token_start <= ts_b;
        param_count <= pc_b;
        error_code  <= err_b;
        if (!ovf) position <= position + irclt_pkg::POS_W'(1);
      end
    end
  end

  // two-byte hold-back
  always_ff @(posedge clk) begin
    if (in_valid) begin
      if (position >= irclt_pkg::POS_W'(2)) begin
        held0 <= held1;
        held1 <= in_byte;
      end else if (position == '0) begin
        held0 <= in_byte;
      end else begin
        held1 <= in_byte;
      end
    end
  end

`ifndef NO_ASSERTIONS
  a_status_last: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_last |-> push.cnt != 2'd0 && push.recs[push.cnt - 2'd1].last)
    else $error("line end without closing status record");
  a_mid_line: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_last |-> push.cnt <= 2'd1)
    else $error("more than one record for a mid-line byte");
  a_clear: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_last |=> position == '0 && phase == irclt_pkg::PH_START)
    else $error("line state not cleared after line end");
`endif

endmodule

// ----- hdl/irclt_queue.sv -----
// record queue of the irc line tokenizer
// takes up to three records per cycle, hands out one per transaction
// depends on irclt_pkg
module irclt_queue (
  input  logic                 clk,
  input  logic                 rst,
  input  irclt_pkg::push_t     push,
  output logic                 room,
  output logic                 out_valid,
  input  logic                 out_ready,
  output irclt_pkg::rec_t      out_rec
);

  irclt_pkg::rec_t              slot [irclt_pkg::Q_DEPTH];
  irclt_pkg::rec_t              slot_next [irclt_pkg::Q_DEPTH];
  logic [irclt_pkg::CNT_W-1:0]  count;
  logic [irclt_pkg::CNT_W-1:0]  count_next;
  logic [irclt_pkg::CNT_W-1:0]  base;
  logic                         pop;

  assign out_valid = count != '0;
  assign out_rec   = slot[0];
  assign pop       = out_valid && out_ready;
  assign room      = count <= irclt_pkg::CNT_W'(irclt_pkg::Q_DEPTH - irclt_pkg::MAX_RECS);

  always_comb begin
    base       = count - irclt_pkg::CNT_W'(pop);
    count_next = base + irclt_pkg::CNT_W'(push.cnt);
    for (int i = 0; i < irclt_pkg::Q_DEPTH - 1; i++) begin
      slot_next[i] = pop ? slot[i + 1] : slot[i];
    end
    slot_next[irclt_pkg::Q_DEPTH-1] = slot[irclt_pkg::Q_DEPTH-1];
    for (int i = 0; i < irclt_pkg::Q_DEPTH; i++) begin
      for (int j = 0; j < irclt_pkg::MAX_RECS; j++) begin
        if ((2'(j) < push.cnt) &&
            (base + irclt_pkg::CNT_W'(j) == irclt_pkg::CNT_W'(i))) begin
          slot_next[i] = push.recs[j];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else begin
      count <= count_next;
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < irclt_pkg::Q_DEPTH; i++) begin
      slot[i] <= slot_next[i];
    end
  end

`ifndef NO_ASSERTIONS
  a_depth: assert property (@(posedge clk) disable iff (rst)
    count <= irclt_pkg::CNT_W'(irclt_pkg::Q_DEPTH))
    else $error("record queue overfilled");
  a_push_room: assert property (@(posedge clk) disable iff (rst)
    push.cnt != 2'd0 |-> room)
    else $error("records pushed without room");
  a_count_step: assert property (@(posedge clk) disable iff (rst)
    pop && push.cnt == 2'd0 |=> count == $past(count) - irclt_pkg::CNT_W'(1))
    else $error("queue count lost track of a pop");
`endif

endmodule

// ----- hdl/irc_line_tokenizer.sv -----
// top level of the irc line tokenizer: stream ports, max_params register
// and record packing; depends on irclt_pkg, irclt_scan and irclt_queue
//
// One line byte is taken per clock on the input stream. Each byte is
// scanned in the cycle it is accepted and its records (at most one token
// record mid-line, at most a token plus the status record on the final
// byte) are written into a four-entry record queue; records leave one per
// clock while m_tready is high. Token records lag their bytes by two
// positions because the last two bytes of a line are held back for the CR
// LF check. The input takes a byte whenever the queue holds at most one
// record, so one byte per cycle is sustained while each byte yields at most
// one record. max_params is to be written on the cfg channel between lines,
// which the block does not check; cfg_ready is always high.
module irc_line_tokenizer (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            s_tvalid,
  output logic                            s_tready,
  input  logic [7:0]                      s_tdata,  // byte_in
  input  logic                            s_tlast,  // line_end
  output logic                            m_tvalid,
  input  logic                            m_tready,
  // tok_offset, tok_length, param_index, status, zero fill
  output logic [irclt_pkg::TDATA_W-1:0]   m_tdata,
  output logic [2:0]                      m_tuser,  // rec_kind
  output logic                            m_tlast,  // rec_last
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [irclt_pkg::PIDX_W-1:0]    cfg_data  // max_params
);

  logic [irclt_pkg::PIDX_W-1:0] max_params;
  irclt_pkg::push_t             push;
  irclt_pkg::rec_t              head;
  logic                         room;
  logic                         in_acc;

  assign cfg_ready = 1'b1;
  assign s_tready  = room;
  assign in_acc    = s_tvalid && s_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      max_params <= irclt_pkg::MAXP_RESET;
    end else if (cfg_valid && cfg_ready) begin
      max_params <= cfg_data;
    end
  end

  irclt_scan u_scan (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_acc),
    .in_byte    (s_tdata),
    .in_last    (s_tlast),
    .max_params (max_params),
    .push       (push)
  );

  irclt_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .room      (room),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .out_rec   (head)
  );

  assign m_tdata = irclt_pkg::TDATA_W'({head.status, head.pidx, head.length, head.offset});
  assign m_tuser = head.kind;
  assign m_tlast = head.last;

endmodule

// ----- sim/irc_line_tokenizer_tb.sv -----
// self-checking testbench of irc_line_tokenizer: line bytes in, token and status records out
// a line-level predictor of the tokenizer checks every record, directed lines first, then random
// depends on irclt_pkg and irc_line_tokenizer
module irc_line_tokenizer_tb;

  localparam int DIR_N       = 28;
  localparam int ITEMS       = 100;
  localparam int PHASES      = 4;
  localparam int SETTLE      = 8;
  localparam int HOLD_CYCLES = 300;
  localparam int CYCLE_LIMIT = 1000000;

  typedef struct packed {
    logic [7:0]         b;
    logic               last;
    logic               cfg;
    logic [3:0]         maxp_v;
    logic               typed;
    irclt_pkg::status_t st;
  } dir_row_t;

  logic                           clk       = 1'b0;
  logic                           rst       = 1'b1;
  logic                           s_tvalid  = 1'b0;
  logic                           s_tready;
  logic [7:0]                     s_tdata   = 8'h00;
  logic                           s_tlast   = 1'b0;
  logic                           m_tvalid;
  logic                           m_tready  = 1'b0;
  logic [irclt_pkg::TDATA_W-1:0]  m_tdata;
  logic [2:0]                     m_tuser;
  logic                           m_tlast;
  logic                           cfg_valid = 1'b0;
  logic                           cfg_ready;
  logic [irclt_pkg::PIDX_W-1:0]   cfg_data  = irclt_pkg::MAXP_RESET;

  // typed expectation travels beside the byte it belongs to
  logic                           drv_typed = 1'b0;
  irclt_pkg::status_t             drv_st    = irclt_pkg::ST_OK;

  logic                           tx_calm    = 1'b0;
  logic                           rx_calm    = 1'b0;
  logic                           hold_ask   = 1'b0;
  logic                           hold_taken = 1'b0;
  int                             hold_left  = 0;
  int                             stall_left = 0;
  int                             cycles     = 0;
  int                             errors     = 0;

  irclt_pkg::rec_t                due_recs[$];
  logic [7:0]                     line_q[$];

  // line state of the predictor
  logic [irclt_pkg::PIDX_W-1:0]   maxp = irclt_pkg::MAXP_RESET;
  irclt_pkg::phase_t              ln_phase;
  int                             ln_pos;
  int                             ln_tok;
  logic [7:0]                     ln_held [2];
  int                             ln_nheld;
  int                             ln_nparam;
  irclt_pkg::status_t             ln_err;

  // "\r\n", ": \x00\r\n", ":p\r\n", " A:  B :\r\n", then max_params 1 and "\xff a b\r\n"
  dir_row_t dir_tab [DIR_N] = '{
    '{irclt_pkg::CH_CR,    1'b0, 1'b0, 4'd0, 1'b0, irclt_pkg::ST_OK},
    '{irclt_pkg::CH_LF,    1'b1, 1'b0, 4'd0, 1'b1, irclt_pkg::ST_BAD_END},
    '{irclt_pkg::CH_COLON, 1'b0, 1'b0, 4'd0, 1'b0, irclt_pkg::ST_OK},
    '{irclt_pkg::CH_SP,    1'b0, 1'b0, 4'd0, 1'b0, irclt_pkg::ST_OK},
    '{8'h00,               1'b0, 1'b0, 4'd0, 1'b0, irclt_pkg::ST_OK},
    '{irclt_pkg::CH_CR,    1'b0, 1'b0, 4'd0, 1'b0, irclt_pkg::ST_OK},
    '{irclt_pkg::CH_LF,    1'b1, 1'b0, 4'd0, 1'b1, irclt_pkg::ST_NO_SPACE},
    '{irclt_pkg::CH_COLON, 1'b0, 1'b0, 4'd0, 1'b0, irclt_pkg::ST_OK},
    '{8'h70,               1'b0, 1'b0, 4'd0, 1'b0, irclt_pkg::ST_OK},
    '{irclt_pkg::CH_CR,    1'b0, 1'b0, 4'd0, 1'b0, irclt_pkg::ST_OK},
    '{irclt_pkg::CH_LF,    1'b1, 1'b0, 4'd0, 1'b1, irclt_pkg::ST_PREFIX},
    '{irclt_pkg::CH_SP,    1'b0, 1'b0, 4'd0, 1'b0, irclt_pkg::ST_OK},
    '{8'h41,               1'b0, 1'b0, 4'd0, 1'b0, irclt_pkg::ST_OK},
    '{irclt_pkg::CH_COLON, 1'b0, 1'b0, 4'd0, 1'b0, irclt_pkg::ST_OK},
    '{irclt_pkg::CH_SP,    1'b0, 1'b0, 4'd0, 1'b0, irclt_pkg::ST_OK},
    '{irclt_pkg::CH_SP,    1'b0, 1'b0, 4'd0, 1'b0, irclt_pkg::ST_OK},
    '{8'h42,               1'b0, 1'b0, 4'd0, 1'b0, irclt_pkg::ST_OK},
    '{irclt_pkg::CH_SP,    1'b0, 1'b0, 4'd0, 1'b0, irclt_pkg::ST_OK},
    '{irclt_pkg::CH_COLON, 1'b0, 1'b0, 4'd0, 1'b0, irclt_pkg::ST_OK},
    '{irclt_pkg::CH_CR,    1'b0, 1'b0, 4'd0, 1'b0, irclt_pkg::ST_OK},
    '{irclt_pkg::CH_LF,    1'b1, 1'b0, 4'd0, 1'b0, irclt_pkg::ST_OK},
    '{8'hFF,               1'b0, 1'b1, 4'd1, 1'b0, irclt_pkg::ST_OK},
    '{irclt_pkg::CH_SP,    1'b0, 1'b0, 4'd0, 1'b0, irclt_pkg::ST_OK},
    '{8'h61,               1'b0, 1'b0, 4'd0, 1'b0, irclt_pkg::ST_OK},
    '{irclt_pkg::CH_SP,    1'b0, 1'b0, 4'd0, 1'b0, irclt_pkg::ST_OK},
    '{8'h62,               1'b0, 1'b0, 4'd0, 1'b0, irclt_pkg::ST_OK},
    '{irclt_pkg::CH_CR,    1'b0, 1'b0, 4'd0, 1'b0, irclt_pkg::ST_OK},
    '{irclt_pkg::CH_LF,    1'b1, 1'b0, 4'd0, 1'b1, irclt_pkg::ST_PARAMS}
  };

  irc_line_tokenizer u_top (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tlast   (s_tlast),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser),
    .m_tlast   (m_tlast),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic void add_due(irclt_pkg::kind_t k, int off, int len, int pidx,
                                  irclt_pkg::status_t st, logic last);
    irclt_pkg::rec_t r;
    r.kind   = k;
    r.offset = off[irclt_pkg::OFF_W-1:0];
    r.length = len[irclt_pkg::OFF_W-1:0];
    r.pidx   = pidx[irclt_pkg::PIDX_W-1:0];
    r.status = st;
    r.last   = last;
    due_recs.push_back(r);
  endfunction

  function automatic void clear_line_state();
    ln_phase   = irclt_pkg::PH_START;
    ln_pos     = 0;
    ln_tok     = 0;
    ln_held[0] = 8'h00;
    ln_held[1] = 8'h00;
    ln_nheld   = 0;
    ln_nparam  = 0;
    ln_err     = irclt_pkg::ST_OK;
  endfunction

  function automatic void open_param(int s, irclt_pkg::phase_t nxt);
    int cap;
    cap = (maxp > irclt_pkg::PARAM_LIMIT) ? int'(irclt_pkg::PARAM_LIMIT) : int'(maxp);
    if (ln_nparam >= cap) begin
      if (ln_err == irclt_pkg::ST_OK) ln_err = irclt_pkg::ST_PARAMS;
      ln_phase = irclt_pkg::PH_HALT;
    end else begin
      ln_nparam++;
      ln_tok   = s;
      ln_phase = nxt;
    end
  endfunction

  // one accepted byte: scan the oldest held byte, and close the line on its last byte
  function automatic void tokenize_byte(logic [7:0] b, logic last, logic typed,
                                        irclt_pkg::status_t tst);
    int                 pos;
    int                 p;
    logic [7:0]         hb;
    irclt_pkg::status_t st;
    pos = ln_pos;
    if (pos >= irclt_pkg::MAX_LINE) begin
      ln_err   = irclt_pkg::ST_LONG;
      ln_phase = irclt_pkg::PH_HALT;
    end else begin
      ln_pos = pos + 1;
    end
    if (ln_nheld >= 2) begin
      hb = ln_held[0];
      p  = pos - 2;
      if (ln_err == irclt_pkg::ST_OK && ln_phase != irclt_pkg::PH_HALT) begin
        if (ln_phase == irclt_pkg::PH_START && hb == irclt_pkg::CH_COLON) begin
          ln_phase = irclt_pkg::PH_PREFIX;
          ln_tok   = p + 1;
        end else begin
          if (ln_phase == irclt_pkg::PH_START) begin
            ln_phase = irclt_pkg::PH_CMD;
            ln_tok   = p;
          end
          case (ln_phase)
            irclt_pkg::PH_PREFIX: if (hb == irclt_pkg::CH_SP) begin
              add_due(irclt_pkg::K_PREFIX, ln_tok, p - ln_tok, 0, irclt_pkg::ST_OK, 1'b0);
              ln_phase = irclt_pkg::PH_CMD;
              ln_tok   = p + 1;
            end
            irclt_pkg::PH_CMD: if (hb == irclt_pkg::CH_SP) begin
              add_due(irclt_pkg::K_CMD, ln_tok, p - ln_tok, 0, irclt_pkg::ST_OK, 1'b0);
              ln_phase = irclt_pkg::PH_GAP;
            end
            irclt_pkg::PH_GAP: if (hb != irclt_pkg::CH_SP) begin
              if (hb == irclt_pkg::CH_COLON) open_param(p + 1, irclt_pkg::PH_TRAIL);
              else open_param(p, irclt_pkg::PH_MIDDLE);
            end
            irclt_pkg::PH_MIDDLE: if (hb == irclt_pkg::CH_SP) begin
              add_due(irclt_pkg::K_MIDDLE, ln_tok, p - ln_tok, ln_nparam - 1,
                      irclt_pkg::ST_OK, 1'b0);
              ln_phase = irclt_pkg::PH_GAP;
            end
            default: ;
          endcase
        end
      end
      ln_held[0] = ln_held[1];
      ln_held[1] = b;
    end else begin
      ln_held[ln_nheld] = b;
      ln_nheld++;
    end
    if (last) begin
      if (ln_err == irclt_pkg::ST_LONG) begin
        st = irclt_pkg::ST_LONG;
      end else if (pos < 2 || ln_held[0] != irclt_pkg::CH_CR ||
                   ln_held[1] != irclt_pkg::CH_LF) begin
        st = irclt_pkg::ST_BAD_END;
      end else if (ln_err != irclt_pkg::ST_OK) begin
        st = ln_err;
      end else begin
        st = irclt_pkg::ST_OK;
        case (ln_phase) inside
          irclt_pkg::PH_PREFIX: st = irclt_pkg::ST_PREFIX;
          irclt_pkg::PH_START, irclt_pkg::PH_CMD: st = irclt_pkg::ST_NO_SPACE;
          irclt_pkg::PH_MIDDLE: add_due(irclt_pkg::K_MIDDLE, ln_tok, pos - 1 - ln_tok,
                                        ln_nparam - 1, irclt_pkg::ST_OK, 1'b0);
          irclt_pkg::PH_TRAIL:  add_due(irclt_pkg::K_TRAIL, ln_tok, pos - 1 - ln_tok,
                                        ln_nparam - 1, irclt_pkg::ST_OK, 1'b0);
          default: ;
        endcase
      end
      if (typed) st = tst;
      add_due(irclt_pkg::K_STATUS, 0, 0, 0, st, 1'b1);
      clear_line_state();
    end
  endfunction

  // input, config and output transactions, handled in that order
  always @(posedge clk) begin
    irclt_pkg::rec_t want;
    irclt_pkg::rec_t got;
    if (rst) begin
      maxp = irclt_pkg::MAXP_RESET;
      clear_line_state();
    end else begin
      if (s_tvalid && s_tready) tokenize_byte(s_tdata, s_tlast, drv_typed, drv_st);
      if (cfg_valid && cfg_ready) maxp = cfg_data;
      if (m_tvalid && m_tready) begin
        got.kind   = irclt_pkg::kind_t'(m_tuser);
        got.offset = m_tdata[8:0];
        got.length = m_tdata[17:9];
        got.pidx   = m_tdata[21:18];
        got.status = irclt_pkg::status_t'(m_tdata[24:22]);
        got.last   = m_tlast;
        if (due_recs.size() == 0) begin
          $display("%0t: unexpected record kind %0d off %0d len %0d idx %0d st %0d last %0b",
                   $time, got.kind, got.offset, got.length, got.pidx, got.status, got.last);
          errors++;
        end else begin
          want = due_recs.pop_front();
          if (got !== want) begin
            $display("%0t: expected kind %0d off %0d len %0d idx %0d st %0d last %0b",
                     $time, want.kind, want.offset, want.length, want.pidx, want.status,
                     want.last);
            $display("%0t:   actual kind %0d off %0d len %0d idx %0d st %0d last %0b",
                     $time, got.kind, got.offset, got.length, got.pidx, got.status, got.last);
            errors++;
          end
        end
      end
    end
  end

  // receiver: random stalls, one long hold-off on request
  always @(posedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
    end else if (hold_left > 0) begin
      m_tready  <= 1'b0;
      hold_left <= hold_left - 1;
    end else if (hold_ask && !hold_taken) begin
      hold_taken <= 1'b1;
      hold_left  <= HOLD_CYCLES;
      m_tready   <= 1'b0;
    end else if (stall_left > 0) begin
      m_tready   <= 1'b0;
      stall_left <= stall_left - 1;
    end else if (rx_calm || $urandom_range(0, 99) < 70) begin
      m_tready <= 1'b1;
    end else begin
      m_tready   <= 1'b0;
      stall_left <= ($urandom_range(0, 99) < 92) ? $urandom_range(0, 2)
                                                 : $urandom_range(12, 35);
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  task automatic send_byte(input logic [7:0] b, input logic last, input logic typed,
                           input irclt_pkg::status_t st);
    s_tvalid  <= 1'b1;
    s_tdata   <= b;
    s_tlast   <= last;
    drv_typed <= typed;
    drv_st    <= st;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
  endtask

  task automatic pause_tx();
    int r;
    if (tx_calm) return;
    r = $urandom_range(0, 99);
    if (r < 70) return;
    s_tvalid <= 1'b0;
    repeat ((r < 96) ? $urandom_range(1, 3) : $urandom_range(10, 40)) @(posedge clk);
  endtask

  // drain every record, let the block settle, then write max_params
  task automatic set_maxp(input logic [irclt_pkg::PIDX_W-1:0] v);
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (due_recs.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= v;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
  endtask

  function automatic logic [7:0] tok_byte();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 8'h61 + 8'($urandom_range(0, 25));
    else if (r < 70) return 8'h30 + 8'($urandom_range(0, 9));
    else if (r < 80) return irclt_pkg::CH_COLON;
    else return 8'($urandom_range(0, 255));
  endfunction

  // mostly well-formed lines with random content, some noise, short and broken ones
  task automatic make_line();
    int r;
    int np;
    line_q.delete();
    r = $urandom_range(0, 99);
    if (r < 12) begin
      repeat ($urandom_range(1, 10)) line_q.push_back(8'($urandom_range(0, 255)));
      return;
    end
    if (r < 20) begin
      repeat ($urandom_range(1, 3)) begin
        case ($urandom_range(0, 2))
          0:       line_q.push_back(irclt_pkg::CH_CR);
          1:       line_q.push_back(irclt_pkg::CH_LF);
          default: line_q.push_back(8'($urandom_range(0, 255)));
        endcase
      end
      return;
    end
    if ($urandom_range(0, 1) == 1) begin
      line_q.push_back(irclt_pkg::CH_COLON);
      repeat ($urandom_range(0, 4)) line_q.push_back(tok_byte());
      if (r >= 24) line_q.push_back(irclt_pkg::CH_SP);
    end
    repeat ($urandom_range(0, 5)) line_q.push_back(tok_byte());
    if (r >= 28) begin
      line_q.push_back(irclt_pkg::CH_SP);
      np = ($urandom_range(0, 99) < 70) ? $urandom_range(0, 3) : $urandom_range(4, 16);
      for (int i = 0; i < np; i++) begin
        repeat ($urandom_range(1, 4)) line_q.push_back(tok_byte());
        if (i < np - 1 || $urandom_range(0, 1) == 1)
          repeat ($urandom_range(1, 3)) line_q.push_back(irclt_pkg::CH_SP);
      end
      if ($urandom_range(0, 1) == 1) begin
        line_q.push_back(irclt_pkg::CH_SP);
        line_q.push_back(irclt_pkg::CH_COLON);
        repeat ($urandom_range(0, 6)) line_q.push_back(8'($urandom_range(0, 255)));
      end
    end
    r = $urandom_range(0, 99);
    if (r < 86) begin
      line_q.push_back(irclt_pkg::CH_CR);
      line_q.push_back(irclt_pkg::CH_LF);
    end else if (r < 90) begin
      line_q.push_back(irclt_pkg::CH_CR);
    end else if (r < 94) begin
      line_q.push_back(irclt_pkg::CH_LF);
    end else if (r < 97) begin
      line_q.push_back(irclt_pkg::CH_LF);
      line_q.push_back(irclt_pkg::CH_CR);
    end
    if (line_q.size() == 0) line_q.push_back(irclt_pkg::CH_LF);
  endtask

  initial begin
    logic [irclt_pkg::PIDX_W-1:0] v;
    int                           sent;
    int                           goal;
    int                           min_lines;
    int                           n;
    sent = 0;
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    for (int k = 0; k < DIR_N; k++) begin
      if (dir_tab[k].cfg) set_maxp(dir_tab[k].maxp_v);
      pause_tx();
      send_byte(dir_tab[k].b, dir_tab[k].last, dir_tab[k].typed, dir_tab[k].st);
      sent++;
    end
    for (int ph = 0; ph < PHASES; ph++) begin
      case (ph)
        0:       v = 4'd15;
        1:       v = 4'd1;
        3:       v = 4'd2;
        default: v = 4'($urandom_range(1, 15));
      endcase
      set_maxp(v);
      // phase 1: receiver holds off while lines keep coming; phase 3: no idling at all
      tx_calm   = (ph == 1 || ph == 3);
      rx_calm   = (ph == 3);
      if (ph == 1) hold_ask = 1'b1;
      min_lines = (ph == 1) ? 3 : 1;
      goal      = DIR_N + ((ph + 1) * (ITEMS - DIR_N)) / PHASES;
      n         = 0;
      while (n < min_lines || sent < goal) begin
        make_line();
        for (int i = 0; i < line_q.size(); i++) begin
          pause_tx();
          send_byte(line_q[i], i == line_q.size() - 1, 1'b0, irclt_pkg::ST_OK);
          sent++;
        end
        n++;
      end
    end
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (due_recs.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
    if (errors == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
hdl/irclt_pkg.sv
hdl/irclt_scan.sv
hdl/irclt_queue.sv
hdl/irc_line_tokenizer.sv
sim/irc_line_tokenizer_tb.sv
